FILE: rtl/pwsl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pwsl_pkg
// Shared types and constants for the proportional wheel speed limiter.
// ---------------------------------------------------------------------------
package pwsl_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_RADIAN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE_CAP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_REVERSE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_REVERSE    = 2'd3;

	// register reset values
	localparam logic [31:0] SPR_RESET = 32'd33377209;
	localparam logic [15:0] CAP_RESET = 16'd1066;

	// field widths
	localparam int SPEED_W = 32;
	localparam int CAP_W   = 16;
	localparam int PROD_W  = 64;
	localparam int RATE_W  = 17;
	localparam int Q_W     = 16;
	localparam int PART_W  = 48;
	// numerator 2*m*cap + peak stays below 2^81
	localparam int NUM_W   = 81;
	// denominator 2*peak stays below 2^65
	localparam int DEN_W   = 65;

	localparam logic [Q_W-1:0] RATE_MAX = 16'hFFFF;

	// item travelling through the division pipeline
	typedef struct packed {
		logic [NUM_W-1:0] num_l;
		logic [NUM_W-1:0] num_r;
		logic [DEN_W-1:0] den;
		logic [Q_W-1:0]   q_l;
		logic [Q_W-1:0]   q_r;
		logic [Q_W-1:0]   plain_l;
		logic [Q_W-1:0]   plain_r;
		logic             neg_l;
		logic             neg_r;
		logic             scaled;
		logic             invalid;
	} div_t;

endpackage

FILE: rtl/pwsl_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pwsl_front
// Four stages: magnitude, steps/s product, peak and rounding, numerator.
// ---------------------------------------------------------------------------
module pwsl_front #(
	parameter int SPEED_FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [pwsl_pkg::SPEED_W-1:0]        left_speed,
	input  logic [pwsl_pkg::SPEED_W-1:0]        right_speed,
	input  logic                                speed_invalid,
	input  logic [31:0]                         steps_per_radian,
	input  logic [pwsl_pkg::CAP_W-1:0]          step_rate_cap,
	input  logic                                left_reverse,
	input  logic                                right_reverse,
	output logic                                out_valid,
	input  logic                                out_ready,
	output pwsl_pkg::div_t                      out_d
);
	import pwsl_pkg::*;

	localparam int PROD_FRAC = SPEED_FRAC_BITS + 16;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic [SPEED_W-1:0] ml_s1, mr_s1;
	logic               nl_s1, nr_s1, inv_s1;
	logic [PROD_W-1:0]  pl_s2, pr_s2;
	logic               nl_s2, nr_s2, inv_s2;
	logic [PROD_W-1:0]  peak_s3;
	logic [PART_W-1:0]  lh_s3, ll_s3, rh_s3, rl_s3;
	logic [Q_W-1:0]     plain_l_s3, plain_r_s3;
	logic               nl_s3, nr_s3, inv_s3, scl_s3;
	div_t               d_s4;

	logic [SPEED_W-1:0] mag_l, mag_r;
	logic [PROD_W-1:0]  peak, capf, half, rs_l, rs_r, rr_l, rr_r;
	logic [NUM_W-1:0]   prod_l, prod_r;

	// stage readiness, a stage loads when empty or when it drains
	assign rdy4 = ~v_s4 | out_ready;
	assign rdy3 = ~v_s3 | rdy4;
	assign rdy2 = ~v_s2 | rdy3;
	assign rdy1 = ~v_s1 | rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// stage 1: two's complement magnitude, the most negative value maps to 2^31
	assign mag_l = left_speed[SPEED_W-1] ? (~left_speed + SPEED_W'(1)) : left_speed;
	assign mag_r = right_speed[SPEED_W-1] ? (~right_speed + SPEED_W'(1)) : right_speed;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			ml_s1  <= mag_l;
			mr_s1  <= mag_r;
			nl_s1  <= left_speed[SPEED_W-1] ^ left_reverse;
			nr_s1  <= right_speed[SPEED_W-1] ^ right_reverse;
			inv_s1 <= speed_invalid;
		end
	end

	// stage 2: steps/s product with PROD_FRAC fraction bits
	always_ff @(posedge clk) begin
		if (rdy2) begin
			pl_s2  <= PROD_W'(ml_s1) * PROD_W'(steps_per_radian);
			pr_s2  <= PROD_W'(mr_s1) * PROD_W'(steps_per_radian);
			nl_s2  <= nl_s1;
			nr_s2  <= nr_s1;
			inv_s2 <= inv_s1;
		end
	end

	// stage 3: peak, cap compare, plain rounding, partial products of m*cap
	assign peak = (pl_s2 > pr_s2) ? pl_s2 : pr_s2;
	assign capf = PROD_W'({step_rate_cap, {PROD_FRAC{1'b0}}});
	assign half = PROD_W'(1) << (PROD_FRAC - 1);
	assign rs_l = pl_s2 + half;
	assign rs_r = pr_s2 + half;
	assign rr_l = rs_l >> PROD_FRAC;
	assign rr_r = rs_r >> PROD_FRAC;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			peak_s3    <= peak;
			scl_s3     <= (peak > capf);
			plain_l_s3 <= (rr_l > PROD_W'(RATE_MAX)) ? RATE_MAX : rr_l[Q_W-1:0];
			plain_r_s3 <= (rr_r > PROD_W'(RATE_MAX)) ? RATE_MAX : rr_r[Q_W-1:0];
			lh_s3      <= PART_W'(pl_s2[PROD_W-1:32]) * PART_W'(step_rate_cap);
			ll_s3      <= PART_W'(pl_s2[31:0]) * PART_W'(step_rate_cap);
			rh_s3      <= PART_W'(pr_s2[PROD_W-1:32]) * PART_W'(step_rate_cap);
			rl_s3      <= PART_W'(pr_s2[31:0]) * PART_W'(step_rate_cap);
			nl_s3      <= nl_s2;
			nr_s3      <= nr_s2;
			inv_s3     <= inv_s2;
		end
	end

	// stage 4: numerator 2*m*cap + peak and denominator 2*peak
	assign prod_l = (NUM_W'(lh_s3) << 32) + NUM_W'(ll_s3);
	assign prod_r = (NUM_W'(rh_s3) << 32) + NUM_W'(rl_s3);

	always_ff @(posedge clk) begin
		if (rdy4) begin
			d_s4.num_l   <= (prod_l << 1) + NUM_W'(peak_s3);
			d_s4.num_r   <= (prod_r << 1) + NUM_W'(peak_s3);
			d_s4.den     <= {peak_s3, 1'b0};
			d_s4.q_l     <= '0;
			d_s4.q_r     <= '0;
			d_s4.plain_l <= plain_l_s3;
			d_s4.plain_r <= plain_r_s3;
			d_s4.neg_l   <= nl_s3;
			d_s4.neg_r   <= nr_s3;
			d_s4.scaled  <= scl_s3;
			d_s4.invalid <= inv_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_d = d_s4;

endmodule

FILE: rtl/pwsl_div_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pwsl_div_step
// One restoring division stage: settles one quotient bit for both wheels.
// ---------------------------------------------------------------------------
module pwsl_div_step #(
	parameter int BIT_IDX = 15
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pwsl_pkg::div_t in_d,
	output logic           out_valid,
	input  logic           out_ready,
	output pwsl_pkg::div_t out_d
);
	import pwsl_pkg::*;

	logic             v_s1;
	div_t             d_s1;
	div_t             nxt;
	logic [NUM_W-1:0] den_sh;
	logic             ge_l, ge_r;

	assign in_ready = ~v_s1 | out_ready;

	// trial subtract of the shifted denominator from each remainder
	assign den_sh = NUM_W'(in_d.den) << BIT_IDX;
	assign ge_l = (in_d.num_l >= den_sh);
	assign ge_r = (in_d.num_r >= den_sh);

	always_comb begin
		nxt = in_d;
		if (ge_l) begin
			nxt.num_l = in_d.num_l - den_sh;
			nxt.q_l[BIT_IDX] = 1'b1;
		end
		if (ge_r) begin
			nxt.num_r = in_d.num_r - den_sh;
			nxt.q_r[BIT_IDX] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			d_s1 <= nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_d = d_s1;

endmodule

FILE: rtl/pwsl_out.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pwsl_out
// Output register: picks scaled or plain magnitude, applies sign and stop.
// ---------------------------------------------------------------------------
module pwsl_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  pwsl_pkg::div_t             in_d,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [pwsl_pkg::RATE_W-1:0] left_step_rate,
	output logic [pwsl_pkg::RATE_W-1:0] right_step_rate,
	output logic                       was_scaled
);
	import pwsl_pkg::*;

	logic              v_s1;
	logic [RATE_W-1:0] left_s1, right_s1;
	logic              scl_s1;
	logic [Q_W-1:0]    mag_l, mag_r;
	logic [RATE_W-1:0] ext_l, ext_r, res_l, res_r;

	assign in_ready = ~v_s1 | out_ready;

	// magnitude choice and sign
	assign mag_l = in_d.scaled ? in_d.q_l : in_d.plain_l;
	assign mag_r = in_d.scaled ? in_d.q_r : in_d.plain_r;
	assign ext_l = RATE_W'(mag_l);
	assign ext_r = RATE_W'(mag_r);
	assign res_l = in_d.neg_l ? (~ext_l + RATE_W'(1)) : ext_l;
	assign res_r = in_d.neg_r ? (~ext_r + RATE_W'(1)) : ext_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// an invalid command stops both wheels
	always_ff @(posedge clk) begin
		if (in_ready) begin
			left_s1  <= in_d.invalid ? '0 : res_l;
			right_s1 <= in_d.invalid ? '0 : res_r;
			scl_s1   <= in_d.scaled & ~in_d.invalid;
		end
	end

	assign out_valid = v_s1;
	assign left_step_rate = left_s1;
	assign right_step_rate = right_s1;
	assign was_scaled = scl_s1;

endmodule

FILE: rtl/proportional_wheel_speed_limiter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// proportional_wheel_speed_limiter
// Converts wheel speed commands to step rates with a proportional cap.
// ---------------------------------------------------------------------------
// Usage:
//  - s_axis carries one command pair per transfer: left and right speed in
//    rad/s (signed fixed point), and an invalid flag in tuser.
//  - m_axis returns one transfer per command: left and right step rates in
//    steps/s and a flag in tuser that is set when the cap scaled the pair.
//  - cfg_we/cfg_addr/cfg_wdata write the four registers; write them only
//    while no command is in flight.
//  - The pipeline has four front stages (magnitude, 32x32 product,
//    peak and partial products, numerator), sixteen division stages (one
//    quotient bit each, both wheels side by side) and the output register.
//  - Throughput is one command per cycle while the receiver does not stall;
//    the sixteen-stage restoring divider sets the depth, not the rate.
//  - Reset empties the pipeline and loads the register defaults.
//  - When the receiver stalls, stages fill up behind the output register;
//    s_axis_tready only falls once every stage holds a command.
// ---------------------------------------------------------------------------
module proportional_wheel_speed_limiter #(
	parameter int SPEED_FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [63:0]                     s_axis_tdata,  // left_speed, right_speed
	input  logic                            s_axis_tuser,  // speed_invalid
	// step rate stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [39:0]                     m_axis_tdata,  // left_step_rate, right_step_rate
	output logic                            m_axis_tuser,  // was_scaled
	// register writes
	input  logic                            cfg_we,
	input  logic [pwsl_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [pwsl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import pwsl_pkg::*;

	localparam int N_STEPS = Q_W;

	logic [31:0]    spr_q;
	logic [CAP_W-1:0] cap_q;
	logic           lrev_q, rrev_q;

	logic           st_valid [0:N_STEPS];
	logic           st_ready [0:N_STEPS];
	div_t           st_d     [0:N_STEPS];

	logic [RATE_W-1:0] left_rate, right_rate;
	logic [RATE_W-1:0] abs_l, abs_r;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q  <= SPR_RESET;
			cap_q  <= CAP_RESET;
			lrev_q <= 1'b0;
			rrev_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_STEPS_PER_RADIAN: spr_q  <= cfg_wdata[31:0];
				REG_STEP_RATE_CAP:    cap_q  <= cfg_wdata[CAP_W-1:0];
				REG_LEFT_REVERSE:     lrev_q <= cfg_wdata[0];
				REG_RIGHT_REVERSE:    rrev_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// front stages
	pwsl_front #(
		.SPEED_FRAC_BITS(SPEED_FRAC_BITS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_axis_tvalid),
		.in_ready         (s_axis_tready),
		.left_speed       (s_axis_tdata[31:0]),
		.right_speed      (s_axis_tdata[63:32]),
		.speed_invalid    (s_axis_tuser),
		.steps_per_radian (spr_q),
		.step_rate_cap    (cap_q),
		.left_reverse     (lrev_q),
		.right_reverse    (rrev_q),
		.out_valid        (st_valid[0]),
		.out_ready        (st_ready[0]),
		.out_d            (st_d[0])
	);

	// division stages, most significant quotient bit first
	for (genvar i = 0; i < N_STEPS; i++) begin : g_div
		pwsl_div_step #(
			.BIT_IDX(N_STEPS - 1 - i)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (st_valid[i]),
			.in_ready  (st_ready[i]),
			.in_d      (st_d[i]),
			.out_valid (st_valid[i+1]),
			.out_ready (st_ready[i+1]),
			.out_d     (st_d[i+1])
		);
	end

	// output register
	pwsl_out u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (st_valid[N_STEPS]),
		.in_ready        (st_ready[N_STEPS]),
		.in_d            (st_d[N_STEPS]),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.left_step_rate  (left_rate),
		.right_step_rate (right_rate),
		.was_scaled      (m_axis_tuser)
	);

	assign m_axis_tdata = {6'b0, right_rate, left_rate};

	// magnitudes for the checks below
	assign abs_l = left_rate[RATE_W-1] ? (~left_rate + RATE_W'(1)) : left_rate;
	assign abs_r = right_rate[RATE_W-1] ? (~right_rate + RATE_W'(1)) : right_rate;

	// no delivered rate ever exceeds the cap
	a_within_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (abs_l <= RATE_W'(cap_q)) && (abs_r <= RATE_W'(cap_q)))
		else $error("step rate above cap");

	// when scaled, the faster wheel lands exactly on the cap
	a_peak_on_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			(abs_l == RATE_W'(cap_q)) || (abs_r == RATE_W'(cap_q)))
		else $error("scaled pair misses the cap");

	// input back-pressure only comes from a stalled, full output
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output stall");

endmodule
